// ===== hdl/tts_pkg.sv =====
package tts_pkg;

    localparam int MAX_TASKS = 64;
    localparam int ID_BITS   = 16;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    // wide enough for a count, a position and a child index
    localparam int WW        = ((CNT_W > 7) ? CNT_W : 7) + 1;

    localparam logic [2:0] ACT_APPEND   = 3'd0;
    localparam logic [2:0] ACT_INSERT   = 3'd1;
    localparam logic [2:0] ACT_MOVE     = 3'd2;
    localparam logic [2:0] ACT_REMOVE   = 3'd3;
    localparam logic [2:0] ACT_SWAP     = 3'd4;
    localparam logic [2:0] ACT_READ     = 3'd5;
    localparam logic [2:0] ACT_CLEAR    = 3'd6;
    localparam logic [2:0] ACT_SCHEDULE = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [4:0] CMD_NOP      = 5'd0;
    localparam logic [4:0] CMD_LOAD     = 5'd1;
    localparam logic [4:0] CMD_RD_I     = 5'd2;
    localparam logic [4:0] CMD_CMP_I    = 5'd3;
    localparam logic [4:0] CMD_RD_POS   = 5'd4;
    localparam logic [4:0] CMD_CAP_A    = 5'd5;
    localparam logic [4:0] CMD_CLR      = 5'd6;
    localparam logic [4:0] CMD_SHU_INIT = 5'd7;
    localparam logic [4:0] CMD_SHU_RD   = 5'd8;
    localparam logic [4:0] CMD_SHU_WR   = 5'd9;
    localparam logic [4:0] CMD_PUT      = 5'd10;
    localparam logic [4:0] CMD_DRP_INIT = 5'd11;
    localparam logic [4:0] CMD_DRP_RD   = 5'd12;
    localparam logic [4:0] CMD_DRP_WR   = 5'd13;
    localparam logic [4:0] CMD_DRP_END  = 5'd14;
    localparam logic [4:0] CMD_SWP_A    = 5'd15;
    localparam logic [4:0] CMD_SWP_B    = 5'd16;
    localparam logic [4:0] CMD_HP_INIT  = 5'd17;
    localparam logic [4:0] CMD_HP_SEL   = 5'd18;
    localparam logic [4:0] CMD_HP_CUR   = 5'd19;
    localparam logic [4:0] CMD_HP_RDL   = 5'd20;
    localparam logic [4:0] CMD_HP_GETL  = 5'd21;
    localparam logic [4:0] CMD_HP_GETR  = 5'd22;
    localparam logic [4:0] CMD_HP_PICK  = 5'd23;
    localparam logic [4:0] CMD_HP_DOWN  = 5'd24;
    localparam logic [4:0] CMD_HP_PUT   = 5'd25;
    localparam logic [4:0] CMD_RES      = 5'd26;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [7:0]         prio;
        logic [15:0]        work;
    } entry_t;

    typedef struct packed {
        logic [4:0] op;
        logic [1:0] res_status;
    } cmd_t;

    typedef struct packed {
        logic [2:0] act;
        logic       scan_end;
        logic       found_a;
        logic       found_b;
        logic       a_eq_pos;
        logic       pos_gt_n;
        logic       pos_ge_n;
        logic       full;
        logic       id_eq;
        logic       work_zero;
        logic       shift_end;
        logic       drop_end;
        logic       heap_end;
        logic       has_left;
        logic       has_right;
        logic       go_down;
    } st_t;

    // a sits above b: smaller prio/work, ties to the lower priority
    function automatic logic ranks_above(entry_t a, entry_t b);
        logic [23:0] lhs;
        logic [23:0] rhs;
        lhs = 24'(a.prio) * 24'(b.work);
        rhs = 24'(b.prio) * 24'(a.work);
        if (lhs != rhs)
            return lhs < rhs;
        return a.prio < b.prio;
    endfunction

endpackage

// ===== hdl/tts_req_if.sv =====
interface tts_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [6:0]  position;
    logic [15:0] task_id;
    logic [15:0] other_id;
    logic [7:0]  prio;
    logic [15:0] work_left;

    modport source (output valid, action, position, task_id, other_id, prio, work_left,
                    input ready);
    modport sink (input valid, action, position, task_id, other_id, prio, work_left,
                  output ready);
endinterface

// ===== hdl/tts_rsp_if.sv =====
interface tts_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic [7:0]  out_prio;
    logic [15:0] out_work;
    logic [6:0]  task_count;

    modport source (output valid, status, out_id, out_prio, out_work, task_count,
                    input ready);
    modport sink (input valid, status, out_id, out_prio, out_work, task_count,
                  output ready);
endinterface

// ===== hdl/tts_datapath.sv =====
module tts_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tts_pkg::cmd_t        cmd,
    output tts_pkg::st_t         st,
    input  logic [2:0]           action,
    input  logic [6:0]           position,
    input  logic [15:0]          task_id,
    input  logic [15:0]          other_id,
    input  logic [7:0]           prio,
    input  logic [15:0]          work_left,
    output logic [1:0]           status,
    output logic [15:0]          out_id,
    output logic [7:0]           out_prio,
    output logic [15:0]          out_work,
    output logic [6:0]           task_count
);

    localparam int IW = tts_pkg::IDX_W;
    localparam int CW = tts_pkg::CNT_W;
    localparam int WW = tts_pkg::WW;

    tts_pkg::entry_t mem [tts_pkg::MAX_TASKS];
    tts_pkg::entry_t rdata_reg;

    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] h_reg, h_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] cidx_reg, cidx_next;
    logic [IW-1:0] a_reg, a_next;
    logic [IW-1:0] b_reg, b_next;
    logic          fa_reg, fa_next;
    logic          fb_reg, fb_next;
    logic          rok_reg, rok_next;
    logic [2:0]    act_reg, act_next;
    logic [6:0]    pos_reg, pos_next;
    logic [tts_pkg::ID_BITS-1:0] id_reg, id_next;
    logic [tts_pkg::ID_BITS-1:0] id2_reg, id2_next;
    logic [7:0]    prio_reg, prio_next;
    logic [15:0]   work_reg, work_next;
    tts_pkg::entry_t ea_reg, ea_next;
    tts_pkg::entry_t eb_reg, eb_next;
    tts_pkg::entry_t cur_reg, cur_next;
    tts_pkg::entry_t cl_reg, cl_next;
    tts_pkg::entry_t cr_reg, cr_next;
    tts_pkg::entry_t c_reg, c_next;
    logic [1:0]    status_reg, status_next;
    tts_pkg::entry_t res_reg, res_next;
    logic [6:0]    count_reg, count_next;

    logic            re, we;
    logic [IW-1:0]   raddr, waddr;
    tts_pkg::entry_t wdata;
    logic [WW-1:0]   left_w;
    tts_pkg::entry_t put_e;

    assign left_w = WW'({k_reg, 1'b1});

    always_comb
    begin
        put_e.id   = id_reg;
        put_e.prio = (act_reg == tts_pkg::ACT_MOVE) ? ea_reg.prio : prio_reg;
        put_e.work = (act_reg == tts_pkg::ACT_MOVE) ? ea_reg.work : work_reg;
    end

    always_comb
    begin
        st.act       = act_reg;
        st.scan_end  = WW'(i_reg) >= WW'(n_reg);
        st.found_a   = fa_reg;
        st.found_b   = fb_reg;
        st.a_eq_pos  = WW'(a_reg) == WW'(pos_reg);
        st.pos_gt_n  = WW'(pos_reg) > WW'(n_reg);
        st.pos_ge_n  = WW'(pos_reg) >= WW'(n_reg);
        st.full      = WW'(n_reg) >= WW'(tts_pkg::MAX_TASKS);
        st.id_eq     = id_reg == id2_reg;
        st.work_zero = work_reg == 16'd0;
        st.shift_end = WW'(i_reg) <= WW'(pos_reg);
        st.drop_end  = WW'(i_reg) + WW'(1) >= WW'(n_reg);
        st.heap_end  = h_reg == CW'(0);
        st.has_left  = left_w < WW'(n_reg);
        st.has_right = left_w + WW'(1) < WW'(n_reg);
        st.go_down   = tts_pkg::ranks_above(c_reg, cur_reg);
    end

    always_comb
    begin
        n_next      = n_reg;
        i_next      = i_reg;
        h_next      = h_reg;
        k_next      = k_reg;
        cidx_next   = cidx_reg;
        a_next      = a_reg;
        b_next      = b_reg;
        fa_next     = fa_reg;
        fb_next     = fb_reg;
        rok_next    = rok_reg;
        act_next    = act_reg;
        pos_next    = pos_reg;
        id_next     = id_reg;
        id2_next    = id2_reg;
        prio_next   = prio_reg;
        work_next   = work_reg;
        ea_next     = ea_reg;
        eb_next     = eb_reg;
        cur_next    = cur_reg;
        cl_next     = cl_reg;
        cr_next     = cr_reg;
        c_next      = c_reg;
        status_next = status_reg;
        res_next    = res_reg;
        count_next  = count_reg;
        re    = 1'b0;
        we    = 1'b0;
        raddr = IW'(i_reg);
        waddr = IW'(i_reg);
        wdata = rdata_reg;
        case (cmd.op)
            tts_pkg::CMD_LOAD:
            begin
                act_next  = action;
                pos_next  = (action == tts_pkg::ACT_APPEND) ? 7'(n_reg) : position;
                id_next   = tts_pkg::ID_BITS'(task_id);
                id2_next  = tts_pkg::ID_BITS'(other_id);
                prio_next = prio;
                work_next = work_left;
                i_next    = CW'(0);
                fa_next   = 1'b0;
                fb_next   = 1'b0;
            end
            tts_pkg::CMD_RD_I:
            begin
                re = 1'b1;
            end
            tts_pkg::CMD_CMP_I:
            begin
                if (!fa_reg && rdata_reg.id == id_reg)
                begin
                    fa_next = 1'b1;
                    a_next  = IW'(i_reg);
                    ea_next = rdata_reg;
                end
                if (!fb_reg && rdata_reg.id == id2_reg)
                begin
                    fb_next = 1'b1;
                    b_next  = IW'(i_reg);
                    eb_next = rdata_reg;
                end
                i_next = i_reg + CW'(1);
            end
            tts_pkg::CMD_RD_POS:
            begin
                re    = 1'b1;
                raddr = IW'(pos_reg);
            end
            tts_pkg::CMD_CAP_A:
            begin
                ea_next = rdata_reg;
            end
            tts_pkg::CMD_CLR:
            begin
                n_next = CW'(0);
            end
            tts_pkg::CMD_SHU_INIT:
            begin
                i_next = n_reg;
            end
            tts_pkg::CMD_SHU_RD:
            begin
                re    = 1'b1;
                raddr = IW'(i_reg - CW'(1));
            end
            tts_pkg::CMD_SHU_WR:
            begin
                we     = 1'b1;
                i_next = i_reg - CW'(1);
            end
            tts_pkg::CMD_PUT:
            begin
                we     = 1'b1;
                waddr  = IW'(pos_reg);
                wdata  = put_e;
                n_next = n_reg + CW'(1);
            end
            tts_pkg::CMD_DRP_INIT:
            begin
                i_next = CW'(a_reg);
            end
            tts_pkg::CMD_DRP_RD:
            begin
                re    = 1'b1;
                raddr = IW'(i_reg + CW'(1));
            end
            tts_pkg::CMD_DRP_WR:
            begin
                we     = 1'b1;
                i_next = i_reg + CW'(1);
            end
            tts_pkg::CMD_DRP_END:
            begin
                n_next = n_reg - CW'(1);
            end
            tts_pkg::CMD_SWP_A:
            begin
                we    = 1'b1;
                waddr = a_reg;
                wdata = eb_reg;
            end
            tts_pkg::CMD_SWP_B:
            begin
                we    = 1'b1;
                waddr = b_reg;
                wdata = ea_reg;
            end
            tts_pkg::CMD_HP_INIT:
            begin
                if (n_reg < CW'(2))
                    h_next = CW'(0);
                else
                    h_next = ((n_reg - CW'(2)) >> 1) + CW'(1);
            end
            tts_pkg::CMD_HP_SEL:
            begin
                h_next = h_reg - CW'(1);
                k_next = h_reg - CW'(1);
                re     = 1'b1;
                raddr  = IW'(h_reg - CW'(1));
            end
            tts_pkg::CMD_HP_CUR:
            begin
                cur_next = rdata_reg;
            end
            tts_pkg::CMD_HP_RDL:
            begin
                re    = 1'b1;
                raddr = IW'(left_w);
            end
            tts_pkg::CMD_HP_GETL:
            begin
                cl_next  = rdata_reg;
                rok_next = st.has_right;
                re       = st.has_right;
                raddr    = IW'(left_w + WW'(1));
            end
            tts_pkg::CMD_HP_GETR:
            begin
                cr_next = rdata_reg;
            end
            tts_pkg::CMD_HP_PICK:
            begin
                if (rok_reg && tts_pkg::ranks_above(cr_reg, cl_reg))
                begin
                    c_next    = cr_reg;
                    cidx_next = CW'(left_w + WW'(1));
                end
                else
                begin
                    c_next    = cl_reg;
                    cidx_next = CW'(left_w);
                end
            end
            tts_pkg::CMD_HP_DOWN:
            begin
                we     = 1'b1;
                waddr  = IW'(k_reg);
                wdata  = c_reg;
                k_next = cidx_reg;
            end
            tts_pkg::CMD_HP_PUT:
            begin
                we    = 1'b1;
                waddr = IW'(k_reg);
                wdata = cur_reg;
            end
            tts_pkg::CMD_RES:
            begin
                status_next = cmd.res_status;
                count_next  = 7'(n_reg);
                if (cmd.res_status == tts_pkg::ST_OK &&
                    (act_reg == tts_pkg::ACT_REMOVE || act_reg == tts_pkg::ACT_READ))
                    res_next = ea_reg;
                else
                    res_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg   <= '0;
            fa_reg  <= 1'b0;
            fb_reg  <= 1'b0;
            rok_reg <= 1'b0;
            act_reg <= tts_pkg::ACT_APPEND;
            i_reg   <= '0;
            h_reg   <= '0;
            k_reg   <= '0;
        end
        else
        begin
            n_reg   <= n_next;
            fa_reg  <= fa_next;
            fb_reg  <= fb_next;
            rok_reg <= rok_next;
            act_reg <= act_next;
            i_reg   <= i_next;
            h_reg   <= h_next;
            k_reg   <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cidx_reg   <= cidx_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        pos_reg    <= pos_next;
        id_reg     <= id_next;
        id2_reg    <= id2_next;
        prio_reg   <= prio_next;
        work_reg   <= work_next;
        ea_reg     <= ea_next;
        eb_reg     <= eb_next;
        cur_reg    <= cur_next;
        cl_reg     <= cl_next;
        cr_reg     <= cr_next;
        c_reg      <= c_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        count_reg  <= count_next;
    end

    assign status     = status_reg;
    assign out_id     = 16'(res_reg.id);
    assign out_prio   = res_reg.prio;
    assign out_work   = res_reg.work;
    assign task_count = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(n_reg) <= WW'(tts_pkg::MAX_TASKS))
        else $error("task count above table size");

    a_put_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == tts_pkg::CMD_PUT |-> WW'(n_reg) < WW'(tts_pkg::MAX_TASKS))
        else $error("entry placed into a full table");

    a_sift_child: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == tts_pkg::CMD_HP_DOWN |-> cidx_reg > k_reg && cidx_reg < n_reg)
        else $error("sift-down moved to an invalid child");

endmodule

// ===== hdl/tts_ctrl.sv =====
module tts_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  tts_pkg::st_t  st,
    output tts_pkg::cmd_t cmd
);

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DISP     = 5'd1;
    localparam logic [4:0] S_SCAN_RD  = 5'd2;
    localparam logic [4:0] S_SCAN_CMP = 5'd3;
    localparam logic [4:0] S_CHECK    = 5'd4;
    localparam logic [4:0] S_SHU_INIT = 5'd5;
    localparam logic [4:0] S_SHU_TEST = 5'd6;
    localparam logic [4:0] S_SHU_WR   = 5'd7;
    localparam logic [4:0] S_DRP_TEST = 5'd8;
    localparam logic [4:0] S_DRP_WR   = 5'd9;
    localparam logic [4:0] S_RD_CAP   = 5'd10;
    localparam logic [4:0] S_SWP_B    = 5'd11;
    localparam logic [4:0] S_HP_NEXT  = 5'd12;
    localparam logic [4:0] S_HP_CUR   = 5'd13;
    localparam logic [4:0] S_HP_CHK   = 5'd14;
    localparam logic [4:0] S_HP_GETL  = 5'd15;
    localparam logic [4:0] S_HP_GETR  = 5'd16;
    localparam logic [4:0] S_HP_PICK  = 5'd17;
    localparam logic [4:0] S_HP_DEC   = 5'd18;
    localparam logic [4:0] S_FIN      = 5'd19;

    logic [4:0] state_reg, state_next;
    logic [1:0] stat_reg, stat_next;
    logic       out_valid_reg, out_valid_next;

    assign req_ready = state_reg == S_IDLE;
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        cmd.op         = tts_pkg::CMD_NOP;
        cmd.res_status = stat_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.op     = tts_pkg::CMD_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                stat_next = tts_pkg::ST_OK;
                case (st.act)
                    tts_pkg::ACT_READ:
                    begin
                        if (st.pos_ge_n)
                        begin
                            stat_next  = tts_pkg::ST_ERR;
                            state_next = S_FIN;
                        end
                        else
                        begin
                            cmd.op     = tts_pkg::CMD_RD_POS;
                            state_next = S_RD_CAP;
                        end
                    end
                    tts_pkg::ACT_CLEAR:
                    begin
                        cmd.op     = tts_pkg::CMD_CLR;
                        state_next = S_FIN;
                    end
                    tts_pkg::ACT_SCHEDULE:
                    begin
                        cmd.op     = tts_pkg::CMD_HP_INIT;
                        state_next = S_HP_NEXT;
                    end
                    default:
                    begin
                        state_next = S_SCAN_RD;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                if (st.scan_end)
                    state_next = S_CHECK;
                else
                begin
                    cmd.op     = tts_pkg::CMD_RD_I;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                cmd.op     = tts_pkg::CMD_CMP_I;
                state_next = S_SCAN_RD;
            end
            S_CHECK:
            begin
                state_next = S_FIN;
                case (st.act)
                    tts_pkg::ACT_APPEND,
                    tts_pkg::ACT_INSERT:
                    begin
                        if (st.found_a || st.work_zero ||
                            (st.act == tts_pkg::ACT_INSERT && st.pos_gt_n))
                            stat_next = tts_pkg::ST_ERR;
                        else if (st.full)
                            stat_next = tts_pkg::ST_FULL;
                        else
                            state_next = S_SHU_INIT;
                    end
                    tts_pkg::ACT_MOVE:
                    begin
                        if (st.pos_ge_n || !st.found_a || st.a_eq_pos)
                            stat_next = tts_pkg::ST_ERR;
                        else
                        begin
                            cmd.op     = tts_pkg::CMD_DRP_INIT;
                            state_next = S_DRP_TEST;
                        end
                    end
                    tts_pkg::ACT_REMOVE:
                    begin
                        if (!st.found_a)
                            stat_next = tts_pkg::ST_ERR;
                        else
                        begin
                            cmd.op     = tts_pkg::CMD_DRP_INIT;
                            state_next = S_DRP_TEST;
                        end
                    end
                    tts_pkg::ACT_SWAP:
                    begin
                        if (!st.found_a || !st.found_b || st.id_eq)
                            stat_next = tts_pkg::ST_ERR;
                        else
                        begin
                            cmd.op     = tts_pkg::CMD_SWP_A;
                            state_next = S_SWP_B;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SHU_INIT:
            begin
                cmd.op     = tts_pkg::CMD_SHU_INIT;
                state_next = S_SHU_TEST;
            end
            S_SHU_TEST:
            begin
                if (st.shift_end)
                begin
                    cmd.op     = tts_pkg::CMD_PUT;
                    state_next = S_FIN;
                end
                else
                begin
                    cmd.op     = tts_pkg::CMD_SHU_RD;
                    state_next = S_SHU_WR;
                end
            end
            S_SHU_WR:
            begin
                cmd.op     = tts_pkg::CMD_SHU_WR;
                state_next = S_SHU_TEST;
            end
            S_DRP_TEST:
            begin
                if (st.drop_end)
                begin
                    cmd.op     = tts_pkg::CMD_DRP_END;
                    // a move puts the task back in after closing the gap
                    state_next = (st.act == tts_pkg::ACT_MOVE) ? S_SHU_INIT : S_FIN;
                end
                else
                begin
                    cmd.op     = tts_pkg::CMD_DRP_RD;
                    state_next = S_DRP_WR;
                end
            end
            S_DRP_WR:
            begin
                cmd.op     = tts_pkg::CMD_DRP_WR;
                state_next = S_DRP_TEST;
            end
            S_RD_CAP:
            begin
                cmd.op     = tts_pkg::CMD_CAP_A;
                state_next = S_FIN;
            end
            S_SWP_B:
            begin
                cmd.op     = tts_pkg::CMD_SWP_B;
                state_next = S_FIN;
            end
            S_HP_NEXT:
            begin
                if (st.heap_end)
                    state_next = S_FIN;
                else
                begin
                    cmd.op     = tts_pkg::CMD_HP_SEL;
                    state_next = S_HP_CUR;
                end
            end
            S_HP_CUR:
            begin
                cmd.op     = tts_pkg::CMD_HP_CUR;
                state_next = S_HP_CHK;
            end
            S_HP_CHK:
            begin
                if (st.has_left)
                begin
                    cmd.op     = tts_pkg::CMD_HP_RDL;
                    state_next = S_HP_GETL;
                end
                else
                begin
                    cmd.op     = tts_pkg::CMD_HP_PUT;
                    state_next = S_HP_NEXT;
                end
            end
            S_HP_GETL:
            begin
                cmd.op     = tts_pkg::CMD_HP_GETL;
                state_next = st.has_right ? S_HP_GETR : S_HP_PICK;
            end
            S_HP_GETR:
            begin
                cmd.op     = tts_pkg::CMD_HP_GETR;
                state_next = S_HP_PICK;
            end
            S_HP_PICK:
            begin
                cmd.op     = tts_pkg::CMD_HP_PICK;
                state_next = S_HP_DEC;
            end
            S_HP_DEC:
            begin
                if (st.go_down)
                begin
                    cmd.op     = tts_pkg::CMD_HP_DOWN;
                    state_next = S_HP_CHK;
                end
                else
                begin
                    cmd.op     = tts_pkg::CMD_HP_PUT;
                    state_next = S_HP_NEXT;
                end
            end
            S_FIN:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.op         = tts_pkg::CMD_RES;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            stat_reg      <= tts_pkg::ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            stat_reg      <= stat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_res_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == tts_pkg::CMD_RES |-> state_reg == S_FIN && (!out_valid_reg || rsp_ready))
        else $error("result loaded over an untaken one");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == tts_pkg::CMD_LOAD |=> state_reg == S_DISP)
        else $error("request load not followed by dispatch");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

endmodule

// ===== hdl/task_table_ratio_heap_scheduler.sv =====
// Task table with heap scheduling.
// req channel (sink): one action per request (append, insert, move, remove,
//   swap, read, clear, schedule) with position, ids, priority and work.
// rsp channel (source): exactly one response per request carrying status,
//   the task read or removed, and the task count after the action.
// Each request is handled alone; req.ready is high only while idle.
// The table sits in one memory with a single read port, so an id lookup reads
//   the stored tasks one by one, shifting on insert/move/remove reads and writes
//   one moved entry at a time, and schedule runs n/2 sifts of up to log2(n)
//   sift-down steps each. Read, clear and a rejected read skip the id lookup,
//   and a full table holds 64 tasks.
// The response waits in an output register; a new request is taken as soon
//   as it is loaded. If rsp.ready stays low, the next response holds in the
//   controller until the register frees.
// Reset empties the table at once; the stored entries need no clearing.
module task_table_ratio_heap_scheduler (
    input logic     clk,
    input logic     rst_n,
    tts_req_if.sink   req,
    tts_rsp_if.source rsp
);

    tts_pkg::cmd_t cmd;
    tts_pkg::st_t  st;

    tts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .st        (st),
        .cmd       (cmd)
    );

    tts_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .st         (st),
        .action     (req.action),
        .position   (req.position),
        .task_id    (req.task_id),
        .other_id   (req.other_id),
        .prio       (req.prio),
        .work_left  (req.work_left),
        .status     (rsp.status),
        .out_id     (rsp.out_id),
        .out_prio   (rsp.out_prio),
        .out_work   (rsp.out_work),
        .task_count (rsp.task_count)
    );

endmodule
